### sv/pidaw_pkg.sv
// Shared types and constants for the PID controller with anti-windup.
package pidaw_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int GAIN_W   = 16;
	localparam int FRAC_W   = 8;
	localparam int LIMIT_W  = 23;
	localparam int DRIVE_W  = 24;
	localparam int INTEG_W  = 32;
	localparam int CFG_W    = 23;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_KP    = 2'd0,
		REG_KI    = 2'd1,
		REG_KD    = 2'd2,
		REG_LIMIT = 2'd3
	} cfg_reg_t;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

	// Input word: one sample pair
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] target_value;
		logic signed [SAMPLE_W-1:0] measured_value;
	} pidaw_in_t;

	// Output word: drive and range flag
	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_value;
		logic                      within_limit;
	} pidaw_out_t;

endpackage

### sv/pid_controller_anti_windup_core.sv
// PID controller core with trapezoidal integral and conditional integration.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    target_value, measured_value
//   out      output     out_valid / out_ready  drive_value, within_limit
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One word per cycle sustained unless out stalls; a word passes input, stage-2 and result registers.
// Three stages: input register, gain products, integral/sum/result register.
// The integral loop closes inside the last stage: one add, saturate, three-way add.
// Stages advance independently, so input keeps flowing while a result waits;
// in_ready drops only when all three stages hold words.
// arst_n clears valid bits, gains, limit (to full scale), last error and integral.
module pid_controller_anti_windup_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pidaw_pkg::pidaw_in_t        in_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pidaw_pkg::pidaw_out_t       out_word,
	input  logic                        cfg_we,
	input  pidaw_pkg::cfg_reg_t         cfg_index,
	input  logic [pidaw_pkg::CFG_W-1:0] cfg_data
);
	import pidaw_pkg::*;

	localparam int DIFF_W = ERR_W + 1;
	localparam int PROD_W = GAIN_W + DIFF_W;
	localparam int ACC_W  = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 1;
	localparam int SUM_W  = ACC_W + 2;

	// Configuration registers
	logic signed [GAIN_W-1:0]  kp_q, ki_q, kd_q;
	logic        [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP:    kp_q    <= cfg_data[GAIN_W-1:0];
				REG_KI:    ki_q    <= cfg_data[GAIN_W-1:0];
				REG_KD:    kd_q    <= cfg_data[GAIN_W-1:0];
				REG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default:   ;
			endcase
		end
	end

	// Stage control
	logic v_s1, v_s2;
	logic out_free, ld_s2;

	assign out_free = !out_valid || out_ready;
	assign ld_s2    = v_s1 && (!v_s2 || out_free);
	assign in_ready = !v_s1 || ld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (!v_s2 || out_free)
				v_s2 <= v_s1;
			if (out_free)
				out_valid <= v_s2;
		end
	end

	// Stage 1: input register
	pidaw_in_t in_s1;

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			in_s1 <= in_word;
	end

	// Error, trapezoid sum, difference and the three gain products
	logic signed [ERR_W-1:0]  err, last_err_q;
	logic signed [DIFF_W-1:0] err_sum, err_diff;
	logic signed [PROD_W-1:0] p_prod, i_prod, d_prod;

	always_comb begin
		err      = ERR_W'(in_s1.target_value) - ERR_W'(in_s1.measured_value);
		err_sum  = DIFF_W'(last_err_q) + DIFF_W'(err);
		err_diff = DIFF_W'(err) - DIFF_W'(last_err_q);
		p_prod   = PROD_W'(kp_q) * PROD_W'(err);
		i_prod   = PROD_W'(ki_q) * PROD_W'(err_sum);
		d_prod   = PROD_W'(kd_q) * PROD_W'(err_diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_err_q <= '0;
		else if (ld_s2)
			last_err_q <= err;
	end

	// Stage 2: reduced terms (floor by arithmetic shift)
	logic signed [PROD_W-1:0] p_s2, i_s2, d_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			p_s2 <= p_prod >>> FRAC_W;
			i_s2 <= i_prod >>> FRAC_W;
			d_s2 <= d_prod >>> FRAC_W;
		end
	end

	// Integral term with 32-bit saturation, then the full sum
	logic signed [INTEG_W-1:0] integ_q, i_term;
	logic signed [ACC_W-1:0]   i_acc;
	logic signed [SUM_W-1:0]   sum, lim_pos, lim_neg;
	logic                      i_ovf, d_ovf, ok;
	logic signed [DRIVE_W-1:0] drive;

	always_comb begin
		i_acc = ACC_W'(integ_q) + ACC_W'(i_s2);
		i_ovf = !(&i_acc[ACC_W-1:INTEG_W-1] || ~|i_acc[ACC_W-1:INTEG_W-1]);
		if (i_ovf)
			i_term = {i_acc[ACC_W-1], {(INTEG_W-1){~i_acc[ACC_W-1]}}};
		else
			i_term = i_acc[INTEG_W-1:0];

		sum     = SUM_W'(p_s2) + SUM_W'(i_term) + SUM_W'(d_s2);
		lim_pos = SUM_W'({1'b0, limit_q});
		lim_neg = -lim_pos;
		ok      = (sum <= lim_pos) && (sum >= lim_neg);

		d_ovf = !(&sum[SUM_W-1:DRIVE_W-1] || ~|sum[SUM_W-1:DRIVE_W-1]);
		if (d_ovf)
			drive = {sum[SUM_W-1], {(DRIVE_W-1){~sum[SUM_W-1]}}};
		else
			drive = sum[DRIVE_W-1:0];
	end

	// Integral write-back only when the sum is inside the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			integ_q <= '0;
		else if (v_s2 && out_free && ok)
			integ_q <= i_term;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			out_word.drive_value  <= drive;
			out_word.within_limit <= ok;
		end
	end

endmodule

### sv/pidaw_check.sv
// Port-level checker for the PID core, bound to the top level.
module pidaw_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input pidaw_pkg::pidaw_out_t       out_word,
	input logic                        cfg_we,
	input pidaw_pkg::cfg_reg_t         cfg_index,
	input logic [pidaw_pkg::CFG_W-1:0] cfg_data
);
	import pidaw_pkg::*;

	logic [1:0]         inflight_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               in_fire, out_fire;
	logic signed [DRIVE_W:0] lim_pos, lim_neg, drive_x;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign lim_pos  = (DRIVE_W+1)'({1'b0, limit_q});
	assign lim_neg  = -lim_pos;
	assign drive_x  = (DRIVE_W+1)'(out_word.drive_value);

	// Words held inside the core
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_fire && !out_fire)
			inflight_q <= inflight_q + 2'd1;
		else if (out_fire && !in_fire)
			inflight_q <= inflight_q - 2'd1;
	end

	// Shadow of the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (cfg_we && cfg_index == REG_LIMIT)
			limit_q <= cfg_data[LIMIT_W-1:0];
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd0 |-> !out_valid)
		else $error("result shown with no word in flight");

	a_room_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3 |-> in_ready)
		else $error("input stalled although a stage is free");

	a_flag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.within_limit |-> drive_x <= lim_pos && drive_x >= lim_neg)
		else $error("in-range flag set for drive outside the limit");

endmodule

bind pid_controller_anti_windup_core pidaw_check u_pidaw_check (.*);
